/* src/urpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urpd_pkg
// Shared widths and result codes for the random pool draw block.
// ----------------------------------------------------------------------------
package urpd_pkg;

    localparam int RND_W  = 16;  // random value width
    localparam int VAL_W  = 8;   // stored entry width
    localparam int CFG_W  = 9;   // pool_size register width
    localparam int STEP_W = $clog2(RND_W);

    localparam logic STATUS_DRAWN = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

endpackage

/* src/urpd_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urpd_mod
// Iterative restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module urpd_mod import urpd_pkg::*; #(
    parameter int DIV_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0]  dvd_reg, dvd_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W:0]    shifted;

    assign shifted = {rem_reg, dvd_reg[RND_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(RND_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (shifted >= {1'b0, divisor}) begin
                rem_next = DIV_W'(shifted - {1'b0, divisor});
            end else begin
                rem_next = DIV_W'(shifted);
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* src/unique_random_pool_draw.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_random_pool_draw
// Draws each value 0..N-1 once, N = min(pool_size, POOL_DEPTH), in a random order.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives exactly one result. A draw
// runs through the empty check, the bit-serial remainder of random_value by
// the live count, the handoff from the remainder unit, the read of the drawn
// slot, the read of the last live entry, the write-back through the pool
// memory and the output load. An empty pool goes from the empty check
// straight to the output load. s_ready returns the cycle the result goes
// valid; a new item is not taken before the last one reaches the output load.
// An item with refill set first sweeps the memory, one entry per cycle, over
// min(pool_size, POOL_DEPTH) entries. The next item is taken while the
// previous result still waits on m_ready. An empty pool returns drawn_value
// 0 with status 1. pool_size goes through the cfg channel (always ready); the
// user must write it only while the block is idle: the block does not enforce it.
// ----------------------------------------------------------------------------
module unique_random_pool_draw import urpd_pkg::*; #(
    parameter int POOL_DEPTH = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_pool_size,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_refill,
    input  logic [RND_W-1:0] s_random_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_drawn_value,
    output logic             m_status
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int SZ_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL    = 3'd1;
    localparam logic [2:0] ST_CHECK   = 3'd2;
    localparam logic [2:0] ST_DIV     = 3'd3;
    localparam logic [2:0] ST_RD_SLOT = 3'd4;
    localparam logic [2:0] ST_RD_LAST = 3'd5;
    localparam logic [2:0] ST_WR      = 3'd6;
    localparam logic [2:0] ST_RESULT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] pool_size_reg, pool_size_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [IDX_W-1:0] fill_idx_reg, fill_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [VAL_W-1:0] res_value_reg, res_value_next;
    logic             res_status_reg, res_status_next;
    logic             m_valid_reg, m_valid_next;
    logic [VAL_W-1:0] m_drawn_value_reg, m_drawn_value_next;
    logic             m_status_reg, m_status_next;

    logic [VAL_W-1:0] pool_mem [POOL_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_we;

    logic             div_start;
    logic             div_done;
    logic [CNT_W-1:0] div_rem;

    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] last_idx;
    logic             s_xfer;

    urpd_mod #(
        .DIV_W (CNT_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign last_idx  = count_reg - 1'b1;

    // refill saturates at the memory depth
    always_comb begin
        if (SZ_W'(pool_size_reg) > SZ_W'(POOL_DEPTH)) begin
            fill_count = CNT_W'(POOL_DEPTH);
        end else begin
            fill_count = CNT_W'(pool_size_reg);
        end
    end

    always_comb begin
        state_next         = state_reg;
        pool_size_next     = pool_size_reg;
        count_next         = count_reg;
        rnd_next           = rnd_reg;
        fill_idx_next      = fill_idx_reg;
        slot_next          = slot_reg;
        res_value_next     = res_value_reg;
        res_status_next    = res_status_reg;
        m_valid_next       = m_valid_reg;
        m_drawn_value_next = m_drawn_value_reg;
        m_status_next      = m_status_reg;
        mem_raddr          = slot_reg;
        mem_waddr          = slot_reg;
        mem_wdata          = rd_data_reg;
        mem_we             = 1'b0;
        div_start          = 1'b0;

        if (cfg_valid) begin
            pool_size_next = cfg_pool_size;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    rnd_next = s_random_value;
                    if (s_refill) begin
                        count_next    = fill_count;
                        fill_idx_next = '0;
                        state_next    = (fill_count != '0) ? ST_FILL : ST_CHECK;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FILL: begin
                mem_we        = 1'b1;
                mem_waddr     = fill_idx_reg;
                mem_wdata     = VAL_W'(fill_idx_reg);
                fill_idx_next = fill_idx_reg + 1'b1;
                if (CNT_W'(fill_idx_reg) == last_idx) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (count_reg == '0) begin
                    res_value_next  = '0;
                    res_status_next = STATUS_EMPTY;
                    state_next      = ST_RESULT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    slot_next  = div_rem[IDX_W-1:0];
                    state_next = ST_RD_SLOT;
                end
            end
            ST_RD_SLOT: begin
                mem_raddr  = slot_reg;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST: begin
                // drawn entry arrives now; fetch the last live entry next
                res_value_next  = rd_data_reg;
                res_status_next = STATUS_DRAWN;
                mem_raddr       = last_idx[IDX_W-1:0];
                state_next      = ST_WR;
            end
            ST_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg;
                mem_wdata  = rd_data_reg;
                count_next = last_idx;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_drawn_value_next = res_value_reg;
                    m_status_next      = res_status_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pool_size_reg <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pool_size_reg <= pool_size_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
        rnd_reg           <= rnd_next;
        fill_idx_reg      <= fill_idx_next;
        slot_reg          <= slot_next;
        res_value_reg     <= res_value_next;
        res_status_reg    <= res_status_next;
        m_drawn_value_reg <= m_drawn_value_next;
        m_status_reg      <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pool_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= pool_mem[mem_raddr];
    end

    assign m_valid       = m_valid_reg;
    assign m_drawn_value = m_drawn_value_reg;
    assign m_status      = m_status_reg;

endmodule

/* src/urpd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urpd_checker
// Port-level checks for the random pool draw block, bound to the top level.
// ----------------------------------------------------------------------------
module urpd_checker import urpd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [VAL_W-1:0] m_drawn_value,
    input  logic             m_status
);

    // items taken but not yet delivered
    logic [1:0] pend_reg, pend_next;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (s_xfer && !m_xfer) begin
            pend_next = pend_reg + 1'b1;
        end else if (!s_xfer && m_xfer) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_EMPTY) |-> m_drawn_value == '0)
        else $error("empty result carries a nonzero value");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer |-> pend_reg != 2'd0)
        else $error("result transfer without an outstanding item");

    a_one_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |-> pend_reg <= 2'd1)
        else $error("item taken with two results outstanding");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_drawn_value) && $stable(m_status)))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind unique_random_pool_draw urpd_checker u_checker (.*);
